>>> rtl/core/pn_pkg.sv
// path normalizer package: transaction structs, character codes, command, kind and status codes
// no dependencies; used by path_normalizer_core

package pn_pkg;

	localparam logic [7:0] SLASH_CH = 8'h2F;
	localparam logic [7:0] DOT_CH   = 8'h2E;
	localparam logic [7:0] TERM_CH  = 8'h00;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_in;
		logic [9:0] read_index;
	} req_t;

	typedef struct packed {
		logic       result_kind;
		logic [1:0] status;
		logic [9:0] path_length;
		logic [7:0] byte_out;
	} rsp_t;

endpackage

>>> rtl/core/pn_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies; used by path_normalizer_core for the result store

module pn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/path_normalizer_core.sv
// path normalizer top level: character-stream path canonicalization and result readback
// depends on pn_pkg (types, codes) and pn_ram (result store)

// The block takes a path one character per push transaction, a character of 0
// ending it, and builds the canonical absolute form in an internal byte store of
// PATH_MAX_LEN entries: slash runs collapse, "." is dropped, ".." removes the last
// kept component (nothing at the root), an empty result becomes "/". The
// terminator returns one status transaction (ok, empty path, too long) with the
// result length; a read transaction returns the byte at read_index, 0 at or past
// the length. Other pushes return nothing. One request is in work at a time:
// req_stall is high until it is finished. The first character of a component
// also passes through ST_SLASH (the leading slash and the character are two
// writes to the single write port). A slash closing a ".." walks back through
// the store to the previous slash, each byte a read (ST_SCAN_RD) and a check
// (ST_SCAN_CHK), since the store read data is registered. After any walk a
// terminator passes through ST_FIN and ST_EMIT, a read through ST_RD_DATA and
// ST_EMIT, where the result moves into the output register; that register
// decouples rsp from req, so a result waiting on rsp_stall holds back only the
// next result, not the next push. The store needs no clearing after reset.

module path_normalizer_core #(
	parameter int PATH_MAX_LEN = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  pn_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output pn_pkg::rsp_t rsp
);

	import pn_pkg::*;

	// store address width, component length width, sum width for the fit check
	localparam int AW = $clog2(PATH_MAX_LEN);
	localparam int CW = AW + 1;
	localparam int SW = AW + 2;
	// width wide enough for both the 10-bit index fields and store positions
	localparam int LW = (AW > 10) ? AW : 10;

	localparam logic [SW-1:0] MAX_S  = SW'(PATH_MAX_LEN);
	localparam logic [LW:0]   MAX_L  = (LW + 1)'(PATH_MAX_LEN);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SLASH    = 7'b0000010,
		ST_SCAN_RD  = 7'b0000100,
		ST_SCAN_CHK = 7'b0001000,
		ST_RD_DATA  = 7'b0010000,
		ST_FIN      = 7'b0100000,
		ST_EMIT     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// path state
	logic [AW-1:0] wp_q, wp_d;        // kept result length so far
	logic [CW-1:0] cl_q, cl_d;        // length of component being received
	logic [15:0]   f2_q, f2_d;        // first two chars of that component
	logic          seen_q, seen_d;    // a character of this path was pushed
	logic          ovf_q, ovf_d;      // this path overflowed
	logic [AW-1:0] final_q, final_d;  // length of last finished result
	logic          term_q, term_d;    // finish the path after the ".." walk
	logic          hit_q, hit_d;      // read index inside the result

	// result handoff
	rsp_t pend_q, pend_d;
	rsp_t out_q;
	logic out_valid_q;
	logic out_load;

	// store ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic          acc;
	logic [CW-1:0] len_inc;
	logic [SW-1:0] idx_s;
	logic          idx_ok;
	logic          fits_inc;
	logic          fits_cur;
	logic          is_dot1;
	logic          is_dot2;
	logic [SW-1:0] wp_close_s;
	logic [LW-1:0] fin_ext;
	logic [LW-1:0] fin_d_ext;
	logic [LW-1:0] ridx_ext;
	logic          read_hit;

	assign req_stall = (state_q != ST_IDLE);
	assign acc       = req_valid & ~req_stall;

	// component bookkeeping
	assign len_inc    = cl_q + CW'(1);
	assign idx_s      = SW'(wp_q) + SW'(len_inc);
	assign idx_ok     = idx_s < MAX_S;
	assign fits_inc   = (SW'(wp_q) + SW'(len_inc) + SW'(2)) <= MAX_S;
	assign fits_cur   = (SW'(wp_q) + SW'(cl_q) + SW'(2)) <= MAX_S;
	assign wp_close_s = SW'(wp_q) + SW'(cl_q) + SW'(1);
	assign is_dot1    = (cl_q == CW'(1)) && (f2_q[7:0] == DOT_CH);
	assign is_dot2    = (cl_q == CW'(2)) && (f2_q[7:0] == DOT_CH) && (f2_q[15:8] == DOT_CH);

	// readback indexing
	assign fin_ext   = LW'(final_q);
	assign fin_d_ext = LW'(final_d);
	assign ridx_ext  = LW'(req.read_index);
	assign read_hit  = (ridx_ext < fin_ext) && ({1'b0, ridx_ext} < MAX_L);

	// output register takes a pending result when it is empty or being drained
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !rsp_stall);

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		cl_d      = cl_q;
		f2_d      = f2_q;
		seen_d    = seen_q;
		ovf_d     = ovf_q;
		final_d   = final_q;
		term_d    = term_q;
		hit_d     = hit_q;
		pend_d    = pend_q;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = SLASH_CH;
		ram_raddr = ridx_ext[AW-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (req.cmd == CMD_READ) begin
						hit_d   = read_hit;
						state_d = ST_RD_DATA;
					end else if (req.char_in == TERM_CH || req.char_in == SLASH_CH) begin
						// close the current component
						if (req.char_in == SLASH_CH) begin
							seen_d = 1'b1;
						end
						term_d  = (req.char_in == TERM_CH);
						state_d = (req.char_in == TERM_CH) ? ST_FIN : ST_IDLE;
						if (seen_q || req.char_in == SLASH_CH) begin
							if (!ovf_q) begin
								cl_d = '0;
								f2_d = '0;
								if (cl_q == '0 || is_dot1) begin
									// nothing kept
								end else if (is_dot2) begin
									if (wp_q != '0) begin
										state_d = ST_SCAN_RD;
									end
								end else if (!fits_cur) begin
									ovf_d = 1'b1;
								end else begin
									wp_d = wp_close_s[AW-1:0];
								end
							end
						end
					end else begin
						// ordinary character
						seen_d = 1'b1;
						if (!ovf_q) begin
							if (len_inc > CW'(2) && !fits_inc) begin
								ovf_d = 1'b1;
							end else begin
								ram_we    = idx_ok;
								ram_waddr = idx_s[AW-1:0];
								ram_wdata = req.char_in;
								cl_d      = len_inc;
								if (len_inc == CW'(1)) begin
									f2_d = {8'h00, req.char_in};
								end else if (len_inc == CW'(2)) begin
									f2_d[15:8] = req.char_in;
								end
								// leading slash of a new component goes in next
								if (cl_q == '0) begin
									state_d = ST_SLASH;
								end
							end
						end
					end
				end
			end
			ST_SLASH: begin
				ram_we    = 1'b1;
				ram_waddr = wp_q;
				ram_wdata = SLASH_CH;
				state_d   = ST_IDLE;
			end
			ST_SCAN_RD: begin
				// step back one byte and fetch it
				ram_raddr = wp_q - AW'(1);
				wp_d      = wp_q - AW'(1);
				state_d   = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (ram_rdata == SLASH_CH || wp_q == '0) begin
					state_d = term_q ? ST_FIN : ST_IDLE;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_RD_DATA: begin
				pend_d.result_kind = KIND_DATA;
				pend_d.status      = STATUS_OK;
				pend_d.path_length = fin_ext[9:0];
				pend_d.byte_out    = hit_q ? ram_rdata : 8'h00;
				state_d            = ST_EMIT;
			end
			ST_FIN: begin
				if (!seen_q) begin
					final_d       = '0;
					pend_d.status = STATUS_EMPTY;
				end else begin
					if (wp_q == '0) begin
						// empty result becomes the root
						ram_we    = 1'b1;
						ram_waddr = '0;
						ram_wdata = SLASH_CH;
						final_d   = AW'(1);
					end else begin
						final_d = wp_q;
					end
					pend_d.status = ovf_q ? STATUS_TOO_LONG : STATUS_OK;
				end
				pend_d.result_kind = KIND_STATUS;
				pend_d.path_length = fin_d_ext[9:0];
				pend_d.byte_out    = 8'h00;
				wp_d               = '0;
				cl_d               = '0;
				f2_d               = '0;
				seen_d             = 1'b0;
				ovf_d              = 1'b0;
				term_d             = 1'b0;
				state_d            = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			cl_q        <= '0;
			f2_q        <= '0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			final_q     <= '0;
			term_q      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			cl_q    <= cl_d;
			f2_q    <= f2_d;
			seen_q  <= seen_d;
			ovf_q   <= ovf_d;
			final_q <= final_d;
			term_q  <= term_d;
			hit_q   <= hit_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload registers
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	pn_ram #(
		.WIDTH(8),
		.DEPTH(PATH_MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
